>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define IMHQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define IMHQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/imhq_pkg.sv
// shared types, codes and default sizes for the indexed max-heap queue
// depends on nothing
`default_nettype none

package imhq_pkg;

    localparam int HEAP_DEPTH_DEF = 1024;
    localparam int TAG_SPACE_DEF  = 1024;
    localparam int KEY_BITS_DEF   = 32;
    localparam int ID_BITS_DEF    = 16;

    localparam logic [10:0] CAP_RESET = 11'd1024;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_CHANGE  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_EX0,
        S_EX1,
        S_UP,
        S_UP_CMP,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_TOP,
        S_TOPD,
        S_PAY
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/imhq_ram.sv
// generic single write port, single read port ram with registered read
// depends on imhq_pkg for default sizes
`default_nettype none

module imhq_ram #(
    parameter int WIDTH = imhq_pkg::KEY_BITS_DEF,
    parameter int DEPTH = imhq_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/indexed_max_heap_queue.sv
// indexed binary max-heap queue: sequencer, heap and tag-map memories
// depends on imhq_pkg, imhq_ram and assert_macros.svh
//
// usage
//   request channel: drive command, tag, key, server_id, video_id and raise
//   start; the request is taken at a clock edge with start high and busy low.
//   result channel: done is high for exactly one cycle with status, the
//   extracted or current top item, item_count, is_empty and is_full.
//   the receiver cannot stall; fields hold to the next result. cfg_write /
//   cfg_data write capacity_limit, only while idle (user's duty, unenforced).
// heap walk per request (at most log2 of depth levels)
//   insert sifts up, extract sifts down from the root, change sifts up
//   and then down; refused requests walk no levels.
//   each level costs one heap memory read going up and two going down
//   (left and right child), whose registered data is compared and then
//   written back; the single heap read port sets the pace. a tag space
//   below 1024 entries is reduced by a reciprocal multiply at acceptance.
// reset
//   the present-flag memory is swept to zero, one entry per cycle, over all
//   TAG_SPACE entries; busy stays high for that sweep. count clears, the
//   limit returns to 1024. the other memories are written before read.
// a new request may be presented in the same cycle as done.
`default_nettype none
`include "assert_macros.svh"

module indexed_max_heap_queue #(
    parameter int HEAP_DEPTH = imhq_pkg::HEAP_DEPTH_DEF,
    parameter int TAG_SPACE  = imhq_pkg::TAG_SPACE_DEF,
    parameter int KEY_BITS   = imhq_pkg::KEY_BITS_DEF,
    parameter int ID_BITS    = imhq_pkg::ID_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         command,
    input  wire logic [9:0]         tag,
    input  wire logic signed [31:0] key,
    input  wire logic [15:0]        server_id,
    input  wire logic [15:0]        video_id,
    // result channel
    output logic                    done,
    output logic [2:0]              status,
    output logic [9:0]              item_tag,
    output logic signed [31:0]      item_key,
    output logic [15:0]             item_server,
    output logic [15:0]             item_video,
    output logic [10:0]             item_count,
    output logic                    is_empty,
    output logic                    is_full,
    // capacity limit register
    input  wire logic               cfg_write,
    input  wire logic [10:0]        cfg_data
);

    localparam int SLOT_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
    localparam int TAG_W  = $clog2(TAG_SPACE);
    localparam int ENT_W  = TAG_W + KEY_BITS;
    localparam int IDX_W  = SLOT_W + 2;
    localparam int LIM_W  = (CNT_W > 11) ? CNT_W : 11;
    localparam int PAY_W  = 2 * ID_BITS;
    localparam int RED_SH = 20;
    localparam logic [20:0] RED_MUL = 21'((2 ** RED_SH + TAG_SPACE - 1) / TAG_SPACE);
    localparam bit NEED_MOD = (TAG_SPACE < 1024);

    // control state
    imhq_pkg::state_t  state_reg, state_next;
    imhq_pkg::status_t status_reg, status_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [10:0]       cap_reg;
    logic [TAG_W-1:0]  clr_reg, clr_next;
    logic              ex_ok_reg, ex_ok_next;
    logic              done_reg, done_next;

    // request and working payload
    logic [1:0]                 cmd_reg, cmd_next;
    logic [9:0]                 tred_reg, tred_next;
    logic [ID_BITS-1:0]         srv_reg, srv_next;
    logic [ID_BITS-1:0]         vid_reg, vid_next;
    logic [SLOT_W-1:0]          pos_reg, pos_next;
    logic [TAG_W-1:0]           hold_tag_reg, hold_tag_next;
    logic signed [KEY_BITS-1:0] hold_key_reg, hold_key_next;
    logic [TAG_W-1:0]           left_tag_reg, left_tag_next;
    logic signed [KEY_BITS-1:0] left_key_reg, left_key_next;
    logic                       right_ok_reg, right_ok_next;
    logic [TAG_W-1:0]           top_tag_reg, top_tag_next;
    logic signed [KEY_BITS-1:0] top_key_reg, top_key_next;

    // result registers
    logic [2:0]         o_status_reg, o_status_next;
    logic [9:0]         o_tag_reg, o_tag_next;
    logic signed [31:0] o_key_reg, o_key_next;
    logic [15:0]        o_srv_reg, o_srv_next;
    logic [15:0]        o_vid_reg, o_vid_next;
    logic [10:0]        o_cnt_reg, o_cnt_next;
    logic               o_empty_reg, o_empty_next;
    logic               o_full_reg, o_full_next;

    // memory ports
    logic              h_we;
    logic [SLOT_W-1:0] h_waddr, h_raddr;
    logic [ENT_W-1:0]  h_wdata, h_rdata;
    logic              s_we;
    logic [TAG_W-1:0]  s_waddr, s_raddr;
    logic [SLOT_W-1:0] s_wdata, s_rdata;
    logic              pr_we;
    logic [TAG_W-1:0]  pr_waddr;
    logic [0:0]        pr_wdata, pr_rdata;
    logic              pay_we;
    logic [TAG_W-1:0]  pay_raddr;
    logic [PAY_W-1:0]  pay_rdata;

    // derived values
    logic [TAG_W-1:0]           tag_cur;
    logic [TAG_W-1:0]           h_rtag;
    logic signed [KEY_BITS-1:0] h_rkey;
    logic [IDX_W-1:0]           lch, rch;
    logic [SLOT_W-1:0]          parent;
    logic [LIM_W-1:0]           lim;
    logic                       full_now;
    logic [30:0]                red_prod;
    logic [19:0]                red_back;
    logic [9:0]                 tag_red;
    logic                       left_gt, right_gt;
    logic signed [KEY_BITS-1:0] big_key;

    assign tag_cur  = TAG_W'(tred_reg);
    assign h_rtag   = h_rdata[ENT_W-1:KEY_BITS];
    assign h_rkey   = h_rdata[KEY_BITS-1:0];
    assign lch      = IDX_W'({pos_reg, 1'b1});
    assign rch      = lch + IDX_W'(1);
    assign parent   = SLOT_W'((pos_reg - SLOT_W'(1)) >> 1);
    assign lim      = (LIM_W'(cap_reg) < LIM_W'(HEAP_DEPTH)) ? LIM_W'(cap_reg)
                                                             : LIM_W'(HEAP_DEPTH);
    assign full_now = (LIM_W'(count_reg) >= lim);

    // tag modulo the tag space: quotient by reciprocal multiply, then subtract
    assign red_prod = 31'(tag) * 31'(RED_MUL);
    assign red_back = 20'(red_prod[29:RED_SH]) * 20'(TAG_SPACE);
    assign tag_red  = NEED_MOD ? (tag - red_back[9:0]) : tag;

    // sift-down choice: ties keep the held item, then prefer the left child
    assign left_gt  = (left_key_reg > hold_key_reg);
    assign big_key  = left_gt ? left_key_reg : hold_key_reg;
    assign right_gt = right_ok_reg && (h_rkey > big_key);

    imhq_ram #(.WIDTH(ENT_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    imhq_ram #(.WIDTH(SLOT_W), .DEPTH(TAG_SPACE)) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    imhq_ram #(.WIDTH(1), .DEPTH(TAG_SPACE)) u_present_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr (tag_cur),
        .rdata (pr_rdata)
    );

    imhq_ram #(.WIDTH(PAY_W), .DEPTH(TAG_SPACE)) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (tag_cur),
        .wdata ({srv_reg, vid_reg}),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        clr_next      = clr_reg;
        ex_ok_next    = ex_ok_reg;
        done_next     = 1'b0;
        cmd_next      = cmd_reg;
        tred_next     = tred_reg;
        srv_next      = srv_reg;
        vid_next      = vid_reg;
        pos_next      = pos_reg;
        hold_tag_next = hold_tag_reg;
        hold_key_next = hold_key_reg;
        left_tag_next = left_tag_reg;
        left_key_next = left_key_reg;
        right_ok_next = right_ok_reg;
        top_tag_next  = top_tag_reg;
        top_key_next  = top_key_reg;
        o_status_next = o_status_reg;
        o_tag_next    = o_tag_reg;
        o_key_next    = o_key_reg;
        o_srv_next    = o_srv_reg;
        o_vid_next    = o_vid_reg;
        o_cnt_next    = o_cnt_reg;
        o_empty_next  = o_empty_reg;
        o_full_next   = o_full_reg;

        // default write: place the held item at the current hole
        h_we      = 1'b0;
        h_waddr   = pos_reg;
        h_wdata   = {hold_tag_reg, hold_key_reg};
        h_raddr   = '0;
        s_we      = 1'b0;
        s_waddr   = hold_tag_reg;
        s_wdata   = pos_reg;
        s_raddr   = tag_cur;
        pr_we     = 1'b0;
        pr_waddr  = tag_cur;
        pr_wdata  = 1'b0;
        pay_we    = 1'b0;
        pay_raddr = top_tag_reg;

        case (state_reg)
            imhq_pkg::S_CLEAR:
            begin
                // sweep present flags to zero after reset
                pr_we    = 1'b1;
                pr_waddr = clr_reg;
                clr_next = clr_reg + TAG_W'(1);
                if (clr_reg == TAG_W'(TAG_SPACE - 1))
                begin
                    state_next = imhq_pkg::S_IDLE;
                end
            end

            imhq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = command;
                    tred_next     = tag_red;
                    srv_next      = ID_BITS'(server_id);
                    vid_next      = ID_BITS'(video_id);
                    hold_key_next = KEY_BITS'(key);
                    ex_ok_next    = 1'b0;
                    status_next   = imhq_pkg::ST_OK;
                    state_next    = imhq_pkg::S_CHECK;
                end
            end

            imhq_pkg::S_CHECK:
            begin
                // present flag and slot of the tag are read here
                hold_tag_next = tag_cur;
                state_next    = imhq_pkg::S_DECIDE;
            end

            imhq_pkg::S_DECIDE:
            begin
                state_next = imhq_pkg::S_TOP;
                case (cmd_reg)
                    imhq_pkg::CMD_INSERT:
                    begin
                        if (full_now)
                        begin
                            status_next = imhq_pkg::ST_FULL;
                        end
                        else if (pr_rdata[0])
                        begin
                            status_next = imhq_pkg::ST_PRESENT;
                        end
                        else
                        begin
                            pay_we     = 1'b1;
                            pr_we      = 1'b1;
                            pr_wdata   = 1'b1;
                            pos_next   = SLOT_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                            state_next = imhq_pkg::S_UP;
                        end
                    end
                    imhq_pkg::CMD_EXTRACT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = imhq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            h_raddr    = '0;
                            state_next = imhq_pkg::S_EX0;
                        end
                    end
                    imhq_pkg::CMD_CHANGE:
                    begin
                        if (!pr_rdata[0])
                        begin
                            status_next = imhq_pkg::ST_ABSENT;
                        end
                        else if (CNT_W'(s_rdata) < count_reg)
                        begin
                            pos_next   = s_rdata;
                            state_next = imhq_pkg::S_UP;
                        end
                    end
                    default:
                    begin
                        state_next = imhq_pkg::S_TOP;
                    end
                endcase
            end

            imhq_pkg::S_EX0:
            begin
                // root arrives; fetch the last entry
                top_tag_next = h_rtag;
                top_key_next = h_rkey;
                h_raddr      = SLOT_W'(count_reg - CNT_W'(1));
                state_next   = imhq_pkg::S_EX1;
            end

            imhq_pkg::S_EX1:
            begin
                hold_tag_next = h_rtag;
                hold_key_next = h_rkey;
                count_next    = count_reg - CNT_W'(1);
                pr_we         = 1'b1;
                pr_waddr      = top_tag_reg;
                pos_next      = '0;
                ex_ok_next    = 1'b1;
                state_next    = imhq_pkg::S_DN;
            end

            imhq_pkg::S_UP:
            begin
                if (pos_reg == '0)
                begin
                    if (cmd_reg == imhq_pkg::CMD_CHANGE)
                    begin
                        state_next = imhq_pkg::S_DN;
                    end
                    else
                    begin
                        h_we       = 1'b1;
                        s_we       = 1'b1;
                        state_next = imhq_pkg::S_TOP;
                    end
                end
                else
                begin
                    h_raddr    = parent;
                    state_next = imhq_pkg::S_UP_CMP;
                end
            end

            imhq_pkg::S_UP_CMP:
            begin
                if (hold_key_reg > h_rkey)
                begin
                    // parent moves down into the hole
                    h_we       = 1'b1;
                    h_wdata    = h_rdata;
                    s_we       = 1'b1;
                    s_waddr    = h_rtag;
                    pos_next   = parent;
                    state_next = imhq_pkg::S_UP;
                end
                else if (cmd_reg == imhq_pkg::CMD_CHANGE)
                begin
                    state_next = imhq_pkg::S_DN;
                end
                else
                begin
                    h_we       = 1'b1;
                    s_we       = 1'b1;
                    state_next = imhq_pkg::S_TOP;
                end
            end

            imhq_pkg::S_DN:
            begin
                if (lch >= IDX_W'(count_reg))
                begin
                    h_we       = 1'b1;
                    s_we       = 1'b1;
                    state_next = imhq_pkg::S_TOP;
                end
                else
                begin
                    h_raddr    = SLOT_W'(lch);
                    state_next = imhq_pkg::S_DN_L;
                end
            end

            imhq_pkg::S_DN_L:
            begin
                left_tag_next = h_rtag;
                left_key_next = h_rkey;
                right_ok_next = (rch < IDX_W'(count_reg));
                h_raddr       = SLOT_W'(rch);
                state_next    = imhq_pkg::S_DN_R;
            end

            imhq_pkg::S_DN_R:
            begin
                if (right_gt)
                begin
                    h_we       = 1'b1;
                    h_wdata    = h_rdata;
                    s_we       = 1'b1;
                    s_waddr    = h_rtag;
                    pos_next   = SLOT_W'(rch);
                    state_next = imhq_pkg::S_DN;
                end
                else if (left_gt)
                begin
                    h_we       = 1'b1;
                    h_wdata    = {left_tag_reg, left_key_reg};
                    s_we       = 1'b1;
                    s_waddr    = left_tag_reg;
                    pos_next   = SLOT_W'(lch);
                    state_next = imhq_pkg::S_DN;
                end
                else
                begin
                    h_we       = 1'b1;
                    s_we       = 1'b1;
                    state_next = imhq_pkg::S_TOP;
                end
            end

            imhq_pkg::S_TOP:
            begin
                if (ex_ok_reg)
                begin
                    pay_raddr  = top_tag_reg;
                    state_next = imhq_pkg::S_PAY;
                end
                else if (count_reg == '0)
                begin
                    // nothing to show: item fields read as zero
                    o_status_next = status_reg;
                    o_tag_next    = '0;
                    o_key_next    = '0;
                    o_srv_next    = '0;
                    o_vid_next    = '0;
                    o_cnt_next    = 11'(count_reg);
                    o_empty_next  = 1'b1;
                    o_full_next   = full_now;
                    done_next     = 1'b1;
                    state_next    = imhq_pkg::S_IDLE;
                end
                else
                begin
                    h_raddr    = '0;
                    state_next = imhq_pkg::S_TOPD;
                end
            end

            imhq_pkg::S_TOPD:
            begin
                top_tag_next = h_rtag;
                top_key_next = h_rkey;
                pay_raddr    = h_rtag;
                state_next   = imhq_pkg::S_PAY;
            end

            imhq_pkg::S_PAY:
            begin
                o_status_next = status_reg;
                o_tag_next    = 10'(top_tag_reg);
                o_key_next    = 32'(top_key_reg);
                o_srv_next    = 16'(pay_rdata[PAY_W-1:ID_BITS]);
                o_vid_next    = 16'(pay_rdata[ID_BITS-1:0]);
                o_cnt_next    = 11'(count_reg);
                o_empty_next  = (count_reg == '0);
                o_full_next   = full_now;
                done_next     = 1'b1;
                state_next    = imhq_pkg::S_IDLE;
            end

            default:
            begin
                state_next = imhq_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= imhq_pkg::S_CLEAR;
            status_reg <= imhq_pkg::ST_OK;
            count_reg  <= '0;
            cap_reg    <= imhq_pkg::CAP_RESET;
            clr_reg    <= '0;
            ex_ok_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            count_reg  <= count_next;
            clr_reg    <= clr_next;
            ex_ok_reg  <= ex_ok_next;
            done_reg   <= done_next;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        tred_reg     <= tred_next;
        srv_reg      <= srv_next;
        vid_reg      <= vid_next;
        pos_reg      <= pos_next;
        hold_tag_reg <= hold_tag_next;
        hold_key_reg <= hold_key_next;
        left_tag_reg <= left_tag_next;
        left_key_reg <= left_key_next;
        right_ok_reg <= right_ok_next;
        top_tag_reg  <= top_tag_next;
        top_key_reg  <= top_key_next;
        o_status_reg <= o_status_next;
        o_tag_reg    <= o_tag_next;
        o_key_reg    <= o_key_next;
        o_srv_reg    <= o_srv_next;
        o_vid_reg    <= o_vid_next;
        o_cnt_reg    <= o_cnt_next;
        o_empty_reg  <= o_empty_next;
        o_full_reg   <= o_full_next;
    end

    assign busy        = (state_reg != imhq_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = o_status_reg;
    assign item_tag    = o_tag_reg;
    assign item_key    = o_key_reg;
    assign item_server = o_srv_reg;
    assign item_video  = o_vid_reg;
    assign item_count  = o_cnt_reg;
    assign is_empty    = o_empty_reg;
    assign is_full     = o_full_reg;

    // an accepted request keeps the block busy in the next cycle
    `IMHQ_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "request not taken")
    // a result is only ever shown once the sequencer is back to idle
    `IMHQ_ASSERT_NEVER(a_done_idle, clk, rst_n, done && busy, "result while busy")
    // the held count never passes the heap depth
    `IMHQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(HEAP_DEPTH), "count overflow")

endmodule

`default_nettype wire
